@@ hdl/assert_macros.svh @@
// assert_macros.svh: assertion macros shared by the checker files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define OLAR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olar assertion failed");

// Next-cycle implication
`define OLAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olar assertion failed");

`endif

@@ hdl/olar_pkg.sv @@
// olar_pkg: command and status codes, payload types and the cell control bundle
// for the ordered list block. No dependencies.
package olar_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  // Command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } rsp_t;

  // Broadcast control for the row of cells
  typedef struct packed {
    logic                    shift;      // every cell not being loaded takes its right neighbor
    logic                    load;       // one cell takes load_data
    logic [POS_W-1:0]        load_idx;
    logic signed [VAL_W-1:0] load_data;
  } cell_ctrl_t;

endpackage

@@ hdl/olar_stream_if.sv @@
// olar_stream_if: valid/ready channel carrying one payload of type T.
// Used with olar_pkg::req_t and olar_pkg::rsp_t.
interface olar_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/olar_cell.sv @@
// olar_cell: one list slot; loads from its right neighbor or from the broadcast bus.
// Depends on olar_pkg.
module olar_cell #(
  parameter int INDEX = 0
) (
  input  logic                            clk,
  input  olar_pkg::cell_ctrl_t            ctrl,
  input  logic signed [olar_pkg::VAL_W-1:0] nbr,
  output logic signed [olar_pkg::VAL_W-1:0] data
);

  localparam logic [olar_pkg::POS_W-1:0] MY_IDX = olar_pkg::POS_W'(INDEX);

  // Targeted load wins over the shift
  always_ff @(posedge clk) begin
    if (ctrl.load && (ctrl.load_idx == MY_IDX)) begin
      data <= ctrl.load_data;
    end else if (ctrl.shift) begin
      data <= nbr;
    end
  end

endmodule

@@ hdl/olar_seq.sv @@
// olar_seq: command sequencer; rotates the cell row through the head cell for
// remove and dump, and holds the output register. Depends on olar_pkg, olar_stream_if.
module olar_seq #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  olar_stream_if.sink                       req,
  olar_stream_if.source                     rsp,
  input  logic signed [olar_pkg::VAL_W-1:0] head,
  output olar_pkg::cell_ctrl_t              ctrl
);

  localparam int CNT_W = olar_pkg::CNT_W;
  localparam int POS_W = olar_pkg::POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic {IDLE, RUN} state_t;

  state_t                           state, state_next;
  logic                             op_dump, op_dump_next;
  logic signed [olar_pkg::VAL_W-1:0] key, key_next;
  logic [CNT_W-1:0]                 count, count_next;
  logic [CNT_W-1:0]                 len, len_next;
  logic [POS_W-1:0]                 step, step_next;
  logic                             found, found_next;
  logic [POS_W-1:0]                 pos, pos_next;
  logic                             out_valid, out_valid_next;
  olar_pkg::rsp_t                   out_data, out_data_next;

  logic             accept, slot_free, last_step, drop, found_now;
  logic [POS_W-1:0] pos_now;
  logic [CNT_W-1:0] len_m1, count_m1;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign req.ready = (state == IDLE) && !out_valid;
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign len_m1    = len - CNT_W'(1);
  assign count_m1  = count - CNT_W'(1);
  assign last_step = ({1'b0, step} == count_m1);
  assign drop      = !op_dump && !found && (head == key);
  assign found_now = found || drop;
  assign pos_now   = drop ? step : pos;

  // Next-state and cell control
  always_comb begin
    state_next     = state;
    op_dump_next   = op_dump;
    key_next       = key;
    count_next     = count;
    len_next       = len;
    step_next      = step;
    found_next     = found;
    pos_next       = pos;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    ctrl           = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      IDLE: begin
        if (accept) begin
          out_data_next.item_value  = req.data.value;
          out_data_next.position    = '0;
          out_data_next.entry_count = count;
          out_data_next.last        = 1'b1;
          case (req.data.cmd)
            olar_pkg::CMD_APPEND: begin
              out_valid_next = 1'b1;
              if (count >= CAP_CNT) begin
                out_data_next.status = olar_pkg::ST_FULL;
              end else begin
                ctrl.load                 = 1'b1;
                ctrl.load_idx             = count[POS_W-1:0];
                ctrl.load_data            = req.data.value;
                count_next                = count + CNT_W'(1);
                out_data_next.status      = olar_pkg::ST_OK;
                out_data_next.position    = count[POS_W-1:0];
                out_data_next.entry_count = count + CNT_W'(1);
              end
            end
            olar_pkg::CMD_REMOVE, olar_pkg::CMD_DUMP: begin
              if (count == '0) begin
                out_valid_next       = 1'b1;
                out_data_next.status = olar_pkg::ST_EMPTY;
                if (req.data.cmd == olar_pkg::CMD_DUMP) begin
                  out_data_next.item_value = '0;
                end
              end else begin
                state_next   = RUN;
                op_dump_next = (req.data.cmd == olar_pkg::CMD_DUMP);
                key_next     = req.data.value;
                len_next     = count;
                step_next    = '0;
                found_next   = 1'b0;
                pos_next     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      RUN: begin
        if (slot_free) begin
          // One rotation step: head leaves cell 0, re-enters at the tail unless dropped
          ctrl.shift     = 1'b1;
          ctrl.load      = !drop;
          ctrl.load_idx  = len_m1[POS_W-1:0];
          ctrl.load_data = head;
          if (drop) begin
            len_next   = len_m1;
            found_next = 1'b1;
            pos_next   = step;
          end
          step_next = step + POS_W'(1);
          if (op_dump) begin
            out_valid_next            = 1'b1;
            out_data_next.status      = olar_pkg::ST_OK;
            out_data_next.item_value  = head;
            out_data_next.position    = step;
            out_data_next.entry_count = count;
            out_data_next.last        = last_step;
          end else if (last_step) begin
            out_valid_next           = 1'b1;
            out_data_next.item_value = key;
            out_data_next.last       = 1'b1;
            if (found_now) begin
              count_next                = count_m1;
              out_data_next.status      = olar_pkg::ST_OK;
              out_data_next.position    = pos_now;
              out_data_next.entry_count = count_m1;
            end else begin
              out_data_next.status      = olar_pkg::ST_NOT_FOUND;
              out_data_next.position    = '0;
              out_data_next.entry_count = count;
            end
          end
          if (last_step) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    op_dump  <= op_dump_next;
    key      <= key_next;
    len      <= len_next;
    step     <= step_next;
    found    <= found_next;
    pos      <= pos_next;
    out_data <= out_data_next;
  end

endmodule

@@ hdl/ordered_list_append_remove.sv @@
// ordered_list_append_remove: bounded ordered list held in a row of cells.
// Depends on olar_pkg, olar_stream_if, olar_cell, olar_seq.
//
//   channel  dir  payload                                          handshake
//   req      in   cmd, value                                       valid/ready
//   rsp      out  status, item_value, position, entry_count, last  valid/ready
//
// Append, and remove or dump of an empty list: result registered.
// Remove and dump of n entries: the command is taken, then the row rotates through cell 0,
// one cell per cycle while rsp is not stalled; dump streams one entry per cycle.
// A new transaction is taken the cycle after the previous result has been delivered.
// Reset empties the list; cell contents are not cleared.
// A stalled rsp freezes the rotation with the pending result held.
module ordered_list_append_remove #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  olar_stream_if.sink   req,
  olar_stream_if.source rsp
);

  olar_pkg::cell_ctrl_t ctrl;
  logic signed [olar_pkg::VAL_W-1:0] cell_data [CAPACITY];

  olar_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .head (cell_data[0]),
    .ctrl (ctrl)
  );

  // Row of cells; on a shift each cell not loaded takes its right neighbor (the last takes zero)
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [olar_pkg::VAL_W-1:0] nbr;
    if (k == CAPACITY - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[k+1];
    end
    olar_cell #(.INDEX(k)) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .nbr  (nbr),
      .data (cell_data[k])
    );
  end

endmodule

@@ hdl/olar_checker.sv @@
// olar_checker: port-level checks for ordered_list_append_remove, bound to the top.
// Depends on olar_pkg and assert_macros.svh.
`include "assert_macros.svh"

module olar_checker #(
  parameter int CAPACITY = 64
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input olar_pkg::rsp_t                rsp_data
);

  localparam logic [olar_pkg::CNT_W-1:0] CAP_CNT = olar_pkg::CNT_W'(CAPACITY);

  // A stalled result holds
  `OLAR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

  // No new transaction is taken while a result is pending
  `OLAR_ASSERT_IMPL(a_one_at_a_time, req_ready, !rsp_valid)

  // Full report only at capacity
  `OLAR_ASSERT_IMPL(a_full_count, rsp_valid && (rsp_data.status == olar_pkg::ST_FULL),
                    (rsp_data.entry_count == CAP_CNT) && (rsp_data.position == '0))

  // Mid-dump results are ok and point inside the list
  `OLAR_ASSERT_IMPL(a_dump_body, rsp_valid && !rsp_data.last,
                    (rsp_data.status == olar_pkg::ST_OK) &&
                    ({1'b0, rsp_data.position} < rsp_data.entry_count))

endmodule

bind ordered_list_append_remove olar_checker #(.CAPACITY(CAPACITY)) u_olar_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

@@ dv/tb_ordered_list_append_remove.sv @@
// tb_ordered_list_append_remove: self-checking testbench for the ordered list block.
// Depends on olar_pkg, olar_stream_if and ordered_list_append_remove; directed then
// random commands, predicted in place and compared field by field on each result.
module tb_ordered_list_append_remove;

  localparam int         CAPACITY   = 64;
  localparam int         CYCLE_MAX  = 200000;
  localparam int         DRAIN_WAIT = 20;
  // Command code the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst;

  olar_stream_if #(.T(olar_pkg::req_t)) req_if ();
  olar_stream_if #(.T(olar_pkg::rsp_t)) rsp_if ();

  ordered_list_append_remove #(.CAPACITY(CAPACITY)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Stimulus and scoreboard storage
  olar_pkg::req_t     cmd_pending_q[$];
  olar_pkg::rsp_t     rsp_due_q[$];
  logic signed [31:0] gen_list[$];   // list contents as the generator sees them
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        fail_count;
  int unsigned        cycle_count;

  // Predicted list state
  logic signed [31:0] list_vals [CAPACITY];
  int unsigned        list_len;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Work out the results of one accepted command and update the list
  task automatic apply_list_cmd(input olar_pkg::req_t r);
    olar_pkg::rsp_t res;
    int unsigned    hit;
    res             = '0;
    res.item_value  = r.value;
    res.last        = 1'b1;
    res.entry_count = olar_pkg::CNT_W'(list_len);
    case (r.cmd)
      olar_pkg::CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = olar_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = r.value;
          res.status          = olar_pkg::ST_OK;
          res.position        = olar_pkg::POS_W'(list_len);
          list_len++;
          res.entry_count     = olar_pkg::CNT_W'(list_len);
        end
        rsp_due_q.push_back(res);
      end
      olar_pkg::CMD_REMOVE: begin
        if (list_len == 0) begin
          res.status = olar_pkg::ST_EMPTY;
        end else begin
          hit = list_len;
          for (int i = 0; i < list_len; i++) begin
            if (hit == list_len && list_vals[i] == r.value) hit = i;
          end
          if (hit == list_len) begin
            res.status = olar_pkg::ST_NOT_FOUND;
          end else begin
            // close the gap, order kept
            for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
            list_len--;
            res.status      = olar_pkg::ST_OK;
            res.position    = olar_pkg::POS_W'(hit);
            res.entry_count = olar_pkg::CNT_W'(list_len);
          end
        end
        rsp_due_q.push_back(res);
      end
      olar_pkg::CMD_DUMP: begin
        if (list_len == 0) begin
          res.status     = olar_pkg::ST_EMPTY;
          res.item_value = '0;
          rsp_due_q.push_back(res);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            res.status     = olar_pkg::ST_OK;
            res.item_value = list_vals[i];
            res.position   = olar_pkg::POS_W'(i);
            res.last       = (i + 1 == list_len);
            rsp_due_q.push_back(res);
          end
        end
      end
      default: ;  // unused code: no result, no change
    endcase
  endtask

  // Compare one field, report a mismatch
  task automatic cmp_field(input string fname, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Queue one command and follow its effect on the list for later picks
  task automatic queue_cmd(input logic [1:0] c, input logic signed [31:0] v);
    olar_pkg::req_t r;
    int             idx;
    r.cmd   = c;
    r.value = v;
    cmd_pending_q.push_back(r);
    if (c == olar_pkg::CMD_APPEND && gen_list.size() < CAPACITY) begin
      gen_list.push_back(v);
    end else if (c == olar_pkg::CMD_REMOVE) begin
      idx = -1;
      foreach (gen_list[i]) if (idx < 0 && gen_list[i] == v) idx = i;
      if (idx >= 0) gen_list.delete(idx);
    end
  endtask

  // Values that collide often, extremes among them
  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(7))
      0:       return 32'sd0;
      1:       return -32'sd1;
      2:       return 32'sd1;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'sd42;
    endcase
  endfunction

  // Random command mix, removes mostly aimed at held values
  task automatic queue_random(input int n);
    int unsigned        pick;
    logic signed [31:0] v;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        v = ($urandom_range(99) < 40) ? pool_value() : $urandom;
        queue_cmd(olar_pkg::CMD_APPEND, v);
      end else if (pick < 83) begin
        if (gen_list.size() > 0 && $urandom_range(99) < 60)
          v = gen_list[$urandom_range(gen_list.size() - 1)];
        else if ($urandom_range(99) < 60)
          v = pool_value();
        else
          v = $urandom;
        queue_cmd(olar_pkg::CMD_REMOVE, v);
      end else if (pick < 96) begin
        queue_cmd(olar_pkg::CMD_DUMP, $urandom);
      end else begin
        queue_cmd(CMD_UNUSED, $urandom);
      end
    end
  endtask

  // Wait until every queued command is taken and every result has come
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_pending_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0);
  endtask

  // Request driver: predict on acceptance, then offer the next command
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) apply_list_cmd(req_if.data);
      if (!req_if.valid || req_if.ready) begin
        if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data  <= cmd_pending_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transaction against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due_q.size() == 0) begin
          $error("unexpected result: status %0d item_value %0d",
                 rsp_if.data.status, rsp_if.data.item_value);
          fail_count++;
        end else begin
          olar_pkg::rsp_t e;
          e = rsp_due_q.pop_front();
          cmp_field("status", e.status, rsp_if.data.status);
          cmp_field("item_value", e.item_value, rsp_if.data.item_value);
          cmp_field("position", e.position, rsp_if.data.position);
          cmp_field("entry_count", e.entry_count, rsp_if.data.entry_count);
          cmp_field("last", e.last, rsp_if.data.last);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("tb_ordered_list_append_remove: FAIL");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, unused code, extremes, duplicates, head/middle/tail removal
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd7);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'sd5);
    queue_cmd(CMD_UNUSED, 32'h1234_5678);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h8000_0000);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h7FFF_FFFF);
    queue_cmd(olar_pkg::CMD_APPEND, 32'sd0);
    queue_cmd(olar_pkg::CMD_APPEND, -32'sd1);
    queue_cmd(olar_pkg::CMD_APPEND, 32'sd1);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h7FFF_FFFF);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h5555_5555);
    queue_cmd(olar_pkg::CMD_APPEND, 32'hAAAA_AAAA);
    queue_cmd(olar_pkg::CMD_DUMP, 32'hFFFF_FFFF);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'h7FFF_FFFF);  // first of two matches
    queue_cmd(olar_pkg::CMD_REMOVE, 32'sd12345);     // no match
    queue_cmd(olar_pkg::CMD_REMOVE, 32'h8000_0000);  // head
    queue_cmd(olar_pkg::CMD_REMOVE, 32'hAAAA_AAAA);  // tail
    queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF);
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd0);
    queue_cmd(olar_pkg::CMD_REMOVE, -32'sd1);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'sd0);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'sd1);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'h7FFF_FFFF);
    queue_cmd(olar_pkg::CMD_REMOVE, 32'h5555_5555);
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd3);
    wait_drained();

    // Fill to capacity, overflow, full dump, removals; no idling
    while (gen_list.size() < CAPACITY) queue_cmd(olar_pkg::CMD_APPEND, $urandom);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h7FFF_FFFF);
    queue_cmd(olar_pkg::CMD_APPEND, 32'h8000_0000);
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd0);
    queue_cmd(olar_pkg::CMD_REMOVE, gen_list[CAPACITY / 2]);
    queue_cmd(olar_pkg::CMD_REMOVE, gen_list[0]);
    queue_cmd(olar_pkg::CMD_REMOVE, gen_list[gen_list.size() - 1]);
    wait_drained();

    // Sender idle most of the time
    send_idle_pct = 74;
    queue_random(6);
    wait_drained();

    // Receiver stalling most of the time, with a long dump
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd0);
    queue_random(5);
    wait_drained();

    // Light idling on both sides
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    queue_random(5);
    queue_cmd(olar_pkg::CMD_DUMP, 32'sd0);
    wait_drained();

    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_ordered_list_append_remove: PASS");
    end else begin
      $display("tb_ordered_list_append_remove: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/olar_pkg.sv
hdl/olar_stream_if.sv
hdl/olar_cell.sv
hdl/olar_seq.sv
hdl/ordered_list_append_remove.sv
hdl/olar_checker.sv
dv/tb_ordered_list_append_remove.sv
